[rtl/splq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// splq_pkg: shared types and constants of the stable priority list queue
// Operation and status codes, the stored entry layout and the priority given
// to an entry moved to the front of an empty list.
// ----------------------------------------------------------------------------
package splq_pkg;

	// Payload field types.
	typedef logic [2:0] op_t;
	typedef logic [7:0] id_t;
	typedef logic [6:0] prio_t;
	typedef logic [1:0] status_t;
	typedef logic [8:0] count_t;

	// Operation codes.
	localparam op_t OP_INSERT = 3'd0;
	localparam op_t OP_POP    = 3'd1;
	localparam op_t OP_REMOVE = 3'd2;
	localparam op_t OP_FRONT  = 3'd3;
	localparam op_t OP_CLEAR  = 3'd4;

	// Status codes.
	localparam status_t STAT_OK        = 2'd0;
	localparam status_t STAT_EMPTY     = 2'd1;
	localparam status_t STAT_FULL      = 2'd2;
	localparam status_t STAT_NOT_FOUND = 2'd3;

	// Priority given by move to front when the list is empty.
	localparam prio_t FRONT_PRIO = 7'd100;

	// One stored list entry.
	typedef struct packed {
		id_t   id;
		prio_t prio;
	} entry_t;

endpackage

[rtl/splq_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// splq_req_if: request channel of the stable priority list queue
// Valid/ready channel carrying one operation with its id and priority.
// ----------------------------------------------------------------------------
interface splq_req_if;
	logic             valid;
	logic             ready;
	splq_pkg::op_t    operation;
	splq_pkg::id_t    item_id;
	splq_pkg::prio_t  item_priority;

	modport source (output valid, output operation, output item_id,
		output item_priority, input ready);
	modport sink (input valid, input operation, input item_id,
		input item_priority, output ready);
endinterface

[rtl/splq_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// splq_rsp_if: result channel of the stable priority list queue
// Valid/ready channel carrying one result per operation.
// ----------------------------------------------------------------------------
interface splq_rsp_if;
	logic              valid;
	logic              ready;
	splq_pkg::id_t     result_id;
	splq_pkg::prio_t   result_priority;
	splq_pkg::status_t status;
	splq_pkg::count_t  entry_count;

	modport source (output valid, output result_id, output result_priority,
		output status, output entry_count, input ready);
	modport sink (input valid, input result_id, input result_priority,
		input status, input entry_count, output ready);
endinterface

[rtl/splq_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// splq_mem: entry store of the stable priority list queue
// Simple dual-port memory with one write and one registered read per cycle.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module splq_mem #(
	parameter int Depth = 256,
	localparam int AddrW = $clog2(Depth)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AddrW-1:0]     waddr,
	input  splq_pkg::entry_t     wdata,
	input  logic [AddrW-1:0]     raddr,
	output splq_pkg::entry_t     rdata
);

	splq_pkg::entry_t mem_q [Depth];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/stable_priority_list_queue.sv]
`timescale 1ns / 1ps
// An operation is taken in its transfer cycle, walks the N stored entries at
// one memory read per cycle, drains the read register and presents the result.
// Insert, pop and remove walk the list once; move to front walks it to delete
// and again to insert at the head, ahead of equal priorities, unless rejected
// as full. Clear, unused codes, a full insert and an empty pop do not walk.
// One operation is in flight at a time; the walk rate is set by the single read
// and write port. Reset empties the list; the entry store itself is not cleared.
// ----------------------------------------------------------------------------
// stable_priority_list_queue: bounded priority queue kept in sorted order
// Entries are held in a memory sorted by descending priority; insert places
// an entry behind its equals. A small sequencer walks the memory, shifting
// entries down to delete or up to insert, with a one-entry carry register.
// ----------------------------------------------------------------------------
module stable_priority_list_queue #(
	parameter int CAPACITY = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	splq_req_if.sink    req,
	splq_rsp_if.source  rsp
);

	localparam int AddrW = $clog2(CAPACITY);
	localparam int CntW  = $clog2(CAPACITY + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DEL  = 5'b00010,
		S_INS  = 5'b00100,
		S_TAIL = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t                state_q;
	logic [CntW-1:0]       count_q;
	logic [CntW-1:0]       rd_idx_q;
	logic                  vld_s1;
	logic [AddrW-1:0]      idx_s1;
	logic                  found_q;
	logic                  placed_q;

	splq_pkg::op_t         op_q;
	splq_pkg::id_t         id_q;
	splq_pkg::prio_t       prio_q;
	splq_pkg::entry_t      cap_q;
	splq_pkg::prio_t       head_q;
	splq_pkg::entry_t      carry_q;
	splq_pkg::id_t         res_id_q;
	splq_pkg::prio_t       res_prio_q;
	splq_pkg::status_t     stat_q;

	splq_pkg::entry_t      rdata_s1;
	logic                  we;
	logic [AddrW-1:0]      waddr;
	splq_pkg::entry_t      wdata;

	logic                  walking;
	logic                  issue;
	logic                  pass_end;
	logic                  match_del;
	logic                  place_now;
	logic                  list_full;
	logic                  front_empty;
	splq_pkg::prio_t       front_prio;

	// Entry store.
	splq_mem #(
		.Depth (CAPACITY)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_idx_q[AddrW-1:0]),
		.rdata (rdata_s1)
	);

	// Walk control: a read is issued while entries remain, and the pass
	// ends once every issued read has been processed.
	assign walking   = (state_q == S_DEL) || (state_q == S_INS);
	assign issue     = walking && (rd_idx_q != count_q);
	assign pass_end  = !vld_s1 && (rd_idx_q == count_q);
	assign list_full = (count_q == CntW'(CAPACITY));

	// Delete pass matches the head for pop, otherwise the first equal id.
	assign match_del = (op_q == splq_pkg::OP_POP) ? (idx_s1 == '0)
		: (rdata_s1.id == id_q);

	// Insert pass places the carry once a lower priority entry is reached, or at the head for move to front.
	assign place_now = placed_q || (op_q == splq_pkg::OP_FRONT)
		|| (rdata_s1.prio < prio_q);

	// Move to front takes the head priority, or the default on an empty list.
	assign front_empty = (count_q == '0) || (found_q && (count_q == CntW'(1)));
	assign front_prio  = front_empty ? splq_pkg::FRONT_PRIO : head_q;

	// Memory write selection.
	always_comb begin
		we    = 1'b0;
		waddr = idx_s1;
		wdata = rdata_s1;
		unique case (state_q)
			S_DEL: begin
				if (vld_s1 && found_q) begin
					we    = 1'b1;
					waddr = idx_s1 - AddrW'(1);
				end
			end
			S_INS: begin
				if (vld_s1 && place_now) begin
					we    = 1'b1;
					wdata = carry_q;
				end
			end
			S_TAIL: begin
				we    = 1'b1;
				waddr = count_q[AddrW-1:0];
				wdata = carry_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Sequencer and list occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
			found_q  <= 1'b0;
			placed_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						rd_idx_q <= '0;
						vld_s1   <= 1'b0;
						found_q  <= 1'b0;
						placed_q <= 1'b0;
						unique case (req.operation)
							splq_pkg::OP_INSERT: begin
								state_q <= list_full ? S_DONE : S_INS;
							end
							splq_pkg::OP_POP: begin
								state_q <= (count_q == '0) ? S_DONE : S_DEL;
							end
							splq_pkg::OP_REMOVE, splq_pkg::OP_FRONT: begin
								state_q <= S_DEL;
							end
							splq_pkg::OP_CLEAR: begin
								count_q <= '0;
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_DEL: begin
					// No read is issued at the end of a pass, so the read
					// register empties here as well.
					vld_s1 <= issue;
					if (issue) begin
						rd_idx_q <= rd_idx_q + CntW'(1);
					end
					if (vld_s1 && !found_q && match_del) begin
						found_q <= 1'b1;
					end
					if (pass_end) begin
						if (found_q) begin
							count_q <= count_q - CntW'(1);
						end
						if (op_q == splq_pkg::OP_FRONT && (found_q || !list_full)) begin
							state_q  <= S_INS;
							rd_idx_q <= '0;
							placed_q <= 1'b0;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_INS: begin
					vld_s1 <= issue;
					if (issue) begin
						rd_idx_q <= rd_idx_q + CntW'(1);
					end
					if (vld_s1 && place_now) begin
						placed_q <= 1'b1;
					end
					if (pass_end) begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					count_q <= count_q + CntW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Operation fields, carry register and result registers.
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[AddrW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					op_q       <= req.operation;
					id_q       <= req.item_id;
					prio_q     <= req.item_priority;
					carry_q    <= '{id: req.item_id, prio: req.item_priority};
					res_id_q   <= '0;
					res_prio_q <= '0;
					if (req.operation == splq_pkg::OP_INSERT && list_full) begin
						stat_q <= splq_pkg::STAT_FULL;
					end else if (req.operation == splq_pkg::OP_POP && count_q == '0) begin
						stat_q <= splq_pkg::STAT_EMPTY;
					end else begin
						stat_q <= splq_pkg::STAT_OK;
					end
				end
			end
			S_DEL: begin
				if (vld_s1 && !found_q && match_del) begin
					cap_q <= rdata_s1;
				end
				// Head priority as it stands once the deletion is done.
				if (vld_s1 && (((idx_s1 == '0) && !match_del)
						|| ((idx_s1 == AddrW'(1)) && found_q))) begin
					head_q <= rdata_s1.prio;
				end
				if (pass_end) begin
					unique case (op_q)
						splq_pkg::OP_POP: begin
							res_id_q   <= cap_q.id;
							res_prio_q <= cap_q.prio;
						end
						splq_pkg::OP_REMOVE: begin
							if (!found_q) begin
								stat_q <= splq_pkg::STAT_NOT_FOUND;
							end
						end
						splq_pkg::OP_FRONT: begin
							if (!found_q && list_full) begin
								stat_q <= splq_pkg::STAT_FULL;
							end else begin
								carry_q    <= '{id: id_q, prio: front_prio};
								res_prio_q <= front_prio;
							end
						end
						default: begin
							stat_q <= stat_q;
						end
					endcase
				end
			end
			S_INS: begin
				if (vld_s1 && place_now) begin
					carry_q <= rdata_s1;
				end
			end
			default: begin
				carry_q <= carry_q;
			end
		endcase
	end

	// Channel outputs.
	assign req.ready           = (state_q == S_IDLE);
	assign rsp.valid           = (state_q == S_DONE);
	assign rsp.result_id       = res_id_q;
	assign rsp.result_priority = res_prio_q;
	assign rsp.status          = stat_q;
	assign rsp.entry_count     = 9'(count_q);

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the stable priority list queue
// Drives insert, pop, remove, move-to-front, clear and spare-code requests,
// with random gaps on the request side and random stalls on the result side.
// A shadow copy of the sorted list predicts every result, and each result
// transfer is checked field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CAPACITY = 256;
	localparam int CLK_HALF = 5;
	localparam int CLK_PERIOD = 2 * CLK_HALF;
	// Slowest operation walks the list twice; allow margin after the last result.
	localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;
	localparam longint TIMEOUT_CYCLES = 3_000_000;

	// Operation codes the block treats as no-ops.
	localparam splq_pkg::op_t OP_SPARE_LO  = 3'd5;
	localparam splq_pkg::op_t OP_SPARE_MID = 3'd6;
	localparam splq_pkg::op_t OP_SPARE_HI  = 3'd7;

	// One result transfer as seen on the result channel.
	typedef struct packed {
		splq_pkg::id_t     result_id;
		splq_pkg::prio_t   result_priority;
		splq_pkg::status_t status;
		splq_pkg::count_t  entry_count;
	} outcome_t;

	// Shadow of the sorted list; predicts the result of each accepted request.
	class priority_list_shadow;
		splq_pkg::id_t   slot_id[CAPACITY];
		splq_pkg::prio_t slot_prio[CAPACITY];
		int unsigned     fill;
		outcome_t        awaited[$];
		int unsigned     error_count;

		function new();
			fill = 0;
			error_count = 0;
		endfunction

		function int unsigned entries();
			return fill;
		endfunction

		function int unsigned outstanding();
			return awaited.size();
		endfunction

		// Any id currently held; the caller makes sure the list is not empty.
		function splq_pkg::id_t stored_id();
			return slot_id[$urandom_range(0, fill - 1)];
		endfunction

		// Position of the first entry with this id, or the fill level if none.
		function int unsigned locate(splq_pkg::id_t id);
			int unsigned i;
			for (i = 0; i < fill; i++) begin
				if (slot_id[i] == id) return i;
			end
			return fill;
		endfunction

		function void delete_slot(int unsigned pos);
			int unsigned i;
			for (i = pos; i + 1 < fill; i++) begin
				slot_id[i] = slot_id[i + 1];
				slot_prio[i] = slot_prio[i + 1];
			end
			fill--;
		endfunction

		function void place_slot(int unsigned pos, splq_pkg::id_t id, splq_pkg::prio_t prio);
			int unsigned i;
			for (i = fill; i > pos; i--) begin
				slot_id[i] = slot_id[i - 1];
				slot_prio[i] = slot_prio[i - 1];
			end
			slot_id[pos] = id;
			slot_prio[pos] = prio;
			fill++;
		endfunction

		// Apply one accepted request to the shadow list and queue its result.
		function void accept_request(splq_pkg::op_t op, splq_pkg::id_t id,
			splq_pkg::prio_t prio);
			outcome_t    want;
			int unsigned pos;
			want = '0;
			want.status = splq_pkg::STAT_OK;
			case (op)
				splq_pkg::OP_INSERT: begin
					if (fill >= CAPACITY) begin
						want.status = splq_pkg::STAT_FULL;
					end else begin
						// New entry goes behind every entry of equal or higher priority.
						pos = 0;
						while (pos < fill && slot_prio[pos] >= prio) pos++;
						place_slot(pos, id, prio);
					end
				end
				splq_pkg::OP_POP: begin
					if (fill == 0) begin
						want.status = splq_pkg::STAT_EMPTY;
					end else begin
						want.result_id = slot_id[0];
						want.result_priority = slot_prio[0];
						delete_slot(0);
					end
				end
				splq_pkg::OP_REMOVE: begin
					pos = locate(id);
					if (pos < fill) begin
						delete_slot(pos);
					end else begin
						want.status = splq_pkg::STAT_NOT_FOUND;
					end
				end
				splq_pkg::OP_FRONT: begin
					pos = locate(id);
					if (pos >= fill && fill >= CAPACITY) begin
						want.status = splq_pkg::STAT_FULL;
					end else begin
						if (pos < fill) delete_slot(pos);
						want.result_priority = (fill > 0) ? slot_prio[0]
							: splq_pkg::FRONT_PRIO;
						place_slot(0, id, want.result_priority);
					end
				end
				splq_pkg::OP_CLEAR: begin
					fill = 0;
				end
				default: begin
				end
			endcase
			want.entry_count = splq_pkg::count_t'(fill);
			awaited.push_back(want);
		endfunction

		task flag_mismatch(string what);
			$display("%0t ns: mismatch: %s", $time, what);
			error_count++;
		endtask

		// Compare a result transfer with the oldest prediction.
		task check_result(outcome_t got);
			outcome_t want;
			if (awaited.size() == 0) begin
				flag_mismatch($sformatf("unexpected result id %0d prio %0d status %0d count %0d",
					got.result_id, got.result_priority, got.status, got.entry_count));
			end else begin
				want = awaited.pop_front();
				if (got.result_id !== want.result_id)
					flag_mismatch($sformatf("result_id expected %0d, got %0d",
						want.result_id, got.result_id));
				if (got.result_priority !== want.result_priority)
					flag_mismatch($sformatf("result_priority expected %0d, got %0d",
						want.result_priority, got.result_priority));
				if (got.status !== want.status)
					flag_mismatch($sformatf("status expected %0d, got %0d",
						want.status, got.status));
				if (got.entry_count !== want.entry_count)
					flag_mismatch($sformatf("entry_count expected %0d, got %0d",
						want.entry_count, got.entry_count));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	splq_req_if req_ch ();
	splq_rsp_if rsp_ch ();

	priority_list_shadow shadow = new();

	int unsigned src_gap_pct = 0;
	int unsigned snk_stall_pct = 0;
	int unsigned stall_left = 0;

	stable_priority_list_queue #(
		.CAPACITY(CAPACITY)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Free-running clock.
	always #CLK_HALF clk = ~clk;

	// Result-side back-pressure: random stall bursts.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else if (snk_stall_pct != 0 && $urandom_range(0, 99) < snk_stall_pct) begin
			stall_left = $urandom_range(0, 7);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Check every result transfer.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			shadow.check_result({rsp_ch.result_id, rsp_ch.result_priority,
				rsp_ch.status, rsp_ch.entry_count});
	end

	// Present one request and hold it until the transfer; valid stays high on
	// return so that a following request can follow without a gap.
	task automatic send_request(splq_pkg::op_t op, splq_pkg::id_t id,
		splq_pkg::prio_t prio);
		if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.item_id <= id;
		req_ch.item_priority <= prio;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		shadow.accept_request(op, id, prio);
	endtask

	// Ids are drawn partly from those held, so that removes and moves hit.
	function automatic splq_pkg::id_t pick_id();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 4 && shadow.entries() > 0) return shadow.stored_id();
		if (roll < 7) return splq_pkg::id_t'($urandom_range(0, 15));
		return splq_pkg::id_t'($urandom_range(0, 255));
	endfunction

	// A narrow band of priorities produces many ties.
	function automatic splq_pkg::prio_t pick_prio();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 4) return splq_pkg::prio_t'($urandom_range(60, 63));
		if (roll < 5) return ($urandom_range(0, 1) != 0) ? 7'd127 : 7'd0;
		return splq_pkg::prio_t'($urandom_range(0, 127));
	endfunction

	// A clear followed by a run of mixed operations on a short list.
	task automatic run_round(int unsigned len);
		int unsigned   roll;
		splq_pkg::op_t op;
		send_request(splq_pkg::OP_CLEAR, pick_id(), pick_prio());
		repeat (len) begin
			roll = $urandom_range(0, 99);
			if (roll < 45) op = splq_pkg::OP_INSERT;
			else if (roll < 60) op = splq_pkg::OP_POP;
			else if (roll < 75) op = splq_pkg::OP_REMOVE;
			else if (roll < 95) op = splq_pkg::OP_FRONT;
			else if (roll < 97) op = splq_pkg::OP_CLEAR;
			else op = splq_pkg::op_t'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
			send_request(op, pick_id(), pick_prio());
		end
	endtask

	// Stimulus and end of run.
	initial begin
		int unsigned roll;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.operation <= splq_pkg::OP_INSERT;
		req_ch.item_id <= '0;
		req_ch.item_priority <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-list cases, extremes, ties, duplicates, spare codes.
		send_request(splq_pkg::OP_POP, 8'h00, 7'h00);
		send_request(splq_pkg::OP_REMOVE, 8'h55, 7'h00);
		send_request(splq_pkg::OP_FRONT, 8'hFF, 7'h7F);
		send_request(splq_pkg::OP_POP, 8'h00, 7'h00);
		send_request(splq_pkg::OP_INSERT, 8'h00, 7'h00);
		send_request(splq_pkg::OP_INSERT, 8'hFF, 7'h7F);
		send_request(splq_pkg::OP_INSERT, 8'h10, 7'h7F);
		send_request(splq_pkg::OP_INSERT, 8'h11, 7'h00);
		send_request(splq_pkg::OP_INSERT, 8'h10, 7'h40);
		send_request(splq_pkg::OP_REMOVE, 8'h10, 7'h00);
		send_request(splq_pkg::OP_REMOVE, 8'h77, 7'h00);
		send_request(splq_pkg::OP_FRONT, 8'h11, 7'h00);
		send_request(splq_pkg::OP_FRONT, 8'hAA, 7'h00);
		send_request(OP_SPARE_LO, 8'hFF, 7'h7F);
		send_request(OP_SPARE_MID, 8'h00, 7'h00);
		send_request(OP_SPARE_HI, 8'hFF, 7'h7F);
		send_request(splq_pkg::OP_POP, 8'h00, 7'h00);
		send_request(splq_pkg::OP_POP, 8'h00, 7'h00);
		send_request(splq_pkg::OP_CLEAR, 8'h00, 7'h00);
		send_request(splq_pkg::OP_POP, 8'h00, 7'h00);
		send_request(splq_pkg::OP_INSERT, 8'h5A, 7'h2A);
		send_request(splq_pkg::OP_INSERT, 8'hA5, 7'h55);
		send_request(splq_pkg::OP_CLEAR, 8'hFF, 7'h7F);

		// Random rounds on short lists with varying idle rates.
		repeat (14) begin
			src_gap_pct = 20 * $urandom_range(0, 2);
			snk_stall_pct = 20 * $urandom_range(0, 2);
			run_round($urandom_range(30, 60));
		end

		// Fill to capacity, then exercise the full-list cases.
		src_gap_pct = 15;
		snk_stall_pct = 15;
		send_request(splq_pkg::OP_CLEAR, 8'h00, 7'h00);
		while (shadow.entries() < CAPACITY)
			send_request(splq_pkg::OP_INSERT, splq_pkg::id_t'($urandom_range(0, 255)),
				pick_prio());
		repeat (50) begin
			if (shadow.entries() < CAPACITY) begin
				send_request(splq_pkg::OP_INSERT, splq_pkg::id_t'($urandom_range(0, 255)),
					pick_prio());
			end else begin
				roll = $urandom_range(0, 4);
				case (roll)
					0: send_request(splq_pkg::OP_INSERT,
						splq_pkg::id_t'($urandom_range(0, 255)), pick_prio());
					1: send_request(splq_pkg::OP_FRONT,
						splq_pkg::id_t'($urandom_range(0, 255)), pick_prio());
					2: send_request(splq_pkg::OP_FRONT, shadow.stored_id(), pick_prio());
					3: send_request(splq_pkg::OP_POP, 8'h00, 7'h00);
					default: send_request(splq_pkg::OP_REMOVE, shadow.stored_id(),
						pick_prio());
				endcase
			end
		end

		// Final stretch at full rate on both sides.
		src_gap_pct = 0;
		snk_stall_pct = 0;
		repeat (3) run_round($urandom_range(35, 50));

		req_ch.valid <= 1'b0;
		while (shadow.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (shadow.error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
